[hw/rtl/spq_pkg.sv]
// shared types, constants and helpers for the sorted priority queue
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int TYPE_W = 8;
  localparam int PRI_W  = 16;
  localparam int SPC_W  = 10;
  localparam int REQ_W  = 4;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  localparam logic [SPC_W-1:0] SPACING_RST = SPC_W'(10);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT        = 4'd0,
    REQ_INSERT_TOP    = 4'd1,
    REQ_INSERT_BOTTOM = 4'd2,
    REQ_PEEK_TOP      = 4'd3,
    REQ_PEEK_CUR      = 4'd4,
    REQ_SKIP          = 4'd5,
    REQ_POP_TOP       = 4'd6,
    REQ_POP_CUR       = 4'd7,
    REQ_CLEAR         = 4'd8
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_FULL         = 2'd1,
    STAT_NONE         = 2'd2,
    STAT_SKIP_REFUSED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic [TYPE_W-1:0]       btype;
    logic signed [PRI_W-1:0] pri;
    logic                    blk;
  } entry_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [PRI_W-1:0] pri;
    logic                    bottom;
    entry_t                  new_entry;
  } cell_ctl_t;

  // saturate a one-bit-grown sum back to the priority range
  function automatic logic signed [PRI_W-1:0] sat_pri(input logic [PRI_W:0] v);
    logic signed [PRI_W-1:0] r;
    if (v[PRI_W] != v[PRI_W-1]) begin
      r = v[PRI_W] ? {1'b1, {(PRI_W-1){1'b0}}} : {1'b0, {(PRI_W-1){1'b1}}};
    end else begin
      r = v[PRI_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/spq_ifs.sv]
// request and response channel interfaces
interface spq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [spq_pkg::REQ_W-1:0]            req_type;
  logic [spq_pkg::TYPE_W-1:0]           build_type;
  logic signed [spq_pkg::PRI_W-1:0]     given_priority;
  logic                                 is_blocking;

  modport source (output valid, req_type, build_type, given_priority, is_blocking,
                  input ready);
  modport sink   (input valid, req_type, build_type, given_priority, is_blocking,
                  output ready);
endinterface

interface spq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 item_valid;
  logic [spq_pkg::TYPE_W-1:0]           item_type;
  logic signed [spq_pkg::PRI_W-1:0]     item_priority;
  logic                                 item_blocking;
  logic [spq_pkg::CNT_W-1:0]            entry_count;
  logic                                 skip_allowed;
  logic [1:0]                           status;

  modport source (output valid, item_valid, item_type, item_priority, item_blocking,
                  entry_count, skip_allowed, status, input ready);
  modport sink   (input valid, item_valid, item_type, item_priority, item_blocking,
                  entry_count, skip_allowed, status, output ready);
endinterface

[hw/rtl/spq_cell.sv]
// one storage cell of the sorted chain, shifts with its neighbours
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               valid_i,
  input  logic               rm_sel,
  input  logic               below_le,
  input  spq_pkg::entry_t    below_q,
  input  spq_pkg::entry_t    above_q,
  output spq_pkg::entry_t    q,
  output logic               le
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // entry sits below the insert point
  assign le = valid_i && !ctl.bottom && ($signed(entry_r.pri) <= $signed(ctl.pri));
  assign q  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      spq_pkg::CELL_INSERT: begin
        if (!le) begin
          entry_nxt = below_le ? ctl.new_entry : below_q;
        end
      end
      spq_pkg::CELL_REMOVE: begin
        if (rm_sel) begin
          entry_nxt = above_q;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[hw/rtl/sorted_priority_queue_with_skip.sv]
// top level: command sequencer, marks and the chain of sorted cells
//
//  channel   direction  handshake            payload
//  in_req    in         valid/ready          req_type, build_type, given_priority,
//                                            is_blocking
//  out_rsp   out        valid/ready          item_*, entry_count, skip_allowed, status
//  cfg       in         cfg_we, no wait      cfg_wdata (priority spacing)
//
//  a command is taken in idle, then the exec state updates the cell chain and the fin
//  state reads the new current entry for skip_allowed; both use the single read mux.
//  the response is loaded into the output register from fin; commands do not overlap.
//  a new command is taken once the previous one has reached the output register,
//  so it may be taken while the previous response still waits.
//  a stalled response holds the sequencer in fin until out_rsp drains.
//  reset clears count, skip count and marks and sets spacing to its default; cell contents are undefined.
module sorted_priority_queue_with_skip (
  input  logic                        clk,
  input  logic                        rst_n,
  spq_req_if.sink                     in_req,
  spq_rsp_if.source                   out_rsp,
  input  logic                        cfg_we,
  input  logic [spq_pkg::SPC_W-1:0]   cfg_wdata
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int CNT_W = spq_pkg::CNT_W;
  localparam int IDX_W = spq_pkg::IDX_W;
  localparam int PRI_W = spq_pkg::PRI_W;
  localparam int SPC_W = spq_pkg::SPC_W;

  spq_pkg::state_t state_r, state_nxt;

  logic                         in_ready;
  logic                         exec_en;
  logic                         out_load;

  logic [SPC_W-1:0]             spacing_r;
  logic [CNT_W-1:0]             held_r, held_nxt;
  logic [IDX_W-1:0]             skip_r, skip_nxt;
  logic signed [PRI_W-1:0]      lowest_r, lowest_nxt;

  logic [spq_pkg::REQ_W-1:0]    req_r;
  spq_pkg::entry_t              cmd_entry_r;
  logic                         bottom_r;

  logic                         res_have_r, res_have_nxt;
  spq_pkg::entry_t              res_item_r, res_item_nxt;
  spq_pkg::status_t             res_stat_r, res_stat_nxt;

  logic                         out_valid_r;
  logic                         out_item_valid_r;
  spq_pkg::entry_t              out_item_r;
  logic [CNT_W-1:0]             out_count_r;
  logic                         out_skip_r;
  spq_pkg::status_t             out_stat_r;

  logic [IDX_W-1:0]             top_idx, cur_idx, rd_idx;
  spq_pkg::entry_t              rd_entry;
  logic                         use_top;
  logic                         cur_ok;
  logic                         can_skip;

  logic signed [PRI_W-1:0]      highest;
  logic [PRI_W:0]               sum_hi, sum_lo;
  logic signed [PRI_W-1:0]      p_eff;
  logic                         bottom_eff;

  spq_pkg::cell_ctl_t           ctl;
  spq_pkg::entry_t              cell_q [DEPTH];
  logic [DEPTH-1:0]             cell_le;
  logic [DEPTH-1:0]             cell_valid;
  logic [DEPTH-1:0]             cell_rm;

  // read port of the chain
  assign top_idx = IDX_W'(held_r - CNT_W'(1));
  assign cur_idx = IDX_W'(held_r - CNT_W'(1) - CNT_W'(skip_r));
  assign use_top = (req_r == spq_pkg::REQ_PEEK_TOP) || (req_r == spq_pkg::REQ_POP_TOP);

  always_comb begin
    unique case (state_r)
      spq_pkg::S_IDLE: rd_idx = top_idx;
      spq_pkg::S_EXEC: rd_idx = use_top ? top_idx : cur_idx;
      spq_pkg::S_FIN:  rd_idx = cur_idx;
      default:         rd_idx = top_idx;
    endcase
  end

  assign rd_entry = cell_q[rd_idx];
  assign cur_ok   = CNT_W'(skip_r) < held_r;
  assign can_skip = ((CNT_W'(skip_r) + CNT_W'(1)) < held_r) && !rd_entry.blk;

  // insert priority worked out at the transfer, marks are stable then
  assign highest = (held_r == '0) ? '0 : rd_entry.pri;
  assign sum_hi  = {highest[PRI_W-1], highest} + {{(PRI_W+1-SPC_W){1'b0}}, spacing_r};
  assign sum_lo  = {lowest_r[PRI_W-1], lowest_r} - {{(PRI_W+1-SPC_W){1'b0}}, spacing_r};

  always_comb begin
    case (in_req.req_type)
      spq_pkg::REQ_INSERT_TOP:    p_eff = spq_pkg::sat_pri(sum_hi);
      spq_pkg::REQ_INSERT_BOTTOM: p_eff = spq_pkg::sat_pri(sum_lo);
      default:                    p_eff = in_req.given_priority;
    endcase
  end

  assign bottom_eff = (held_r == '0) || (p_eff <= lowest_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::S_IDLE: if (in_req.valid) state_nxt = spq_pkg::S_EXEC;
      spq_pkg::S_EXEC: state_nxt = spq_pkg::S_FIN;
      spq_pkg::S_FIN:  if (!out_valid_r || out_rsp.ready) state_nxt = spq_pkg::S_IDLE;
      default:         state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      spq_pkg::S_IDLE: in_ready = 1'b1;
      spq_pkg::S_EXEC: exec_en  = 1'b1;
      spq_pkg::S_FIN:  out_load = !out_valid_r || out_rsp.ready;
      default:         in_ready = 1'b0;
    endcase
  end

  assign in_req.ready = in_ready;

  // command execution
  always_comb begin
    held_nxt      = held_r;
    skip_nxt      = skip_r;
    lowest_nxt    = lowest_r;
    res_have_nxt  = res_have_r;
    res_item_nxt  = res_item_r;
    res_stat_nxt  = res_stat_r;
    ctl.op        = spq_pkg::CELL_HOLD;
    ctl.pri       = cmd_entry_r.pri;
    ctl.bottom    = bottom_r;
    ctl.new_entry = cmd_entry_r;
    if (exec_en) begin
      res_have_nxt = 1'b0;
      res_item_nxt = '0;
      res_stat_nxt = spq_pkg::STAT_OK;
      case (req_r)
        spq_pkg::REQ_INSERT, spq_pkg::REQ_INSERT_TOP, spq_pkg::REQ_INSERT_BOTTOM: begin
          if (held_r == CNT_W'(DEPTH)) begin
            res_stat_nxt = spq_pkg::STAT_FULL;
          end else begin
            ctl.op   = spq_pkg::CELL_INSERT;
            held_nxt = held_r + CNT_W'(1);
            if ((held_r == '0) || (cmd_entry_r.pri < lowest_r)) begin
              lowest_nxt = cmd_entry_r.pri;
            end
          end
        end
        spq_pkg::REQ_PEEK_TOP: begin
          skip_nxt = '0;
          if (held_r == '0) begin
            res_stat_nxt = spq_pkg::STAT_NONE;
          end else begin
            res_have_nxt = 1'b1;
            res_item_nxt = rd_entry;
          end
        end
        spq_pkg::REQ_PEEK_CUR: begin
          if (!cur_ok) begin
            res_stat_nxt = spq_pkg::STAT_NONE;
          end else begin
            res_have_nxt = 1'b1;
            res_item_nxt = rd_entry;
          end
        end
        spq_pkg::REQ_SKIP: begin
          if (can_skip) begin
            skip_nxt = skip_r + IDX_W'(1);
          end else begin
            res_stat_nxt = spq_pkg::STAT_SKIP_REFUSED;
          end
        end
        spq_pkg::REQ_POP_TOP, spq_pkg::REQ_POP_CUR: begin
          if ((use_top && (held_r == '0)) || (!use_top && !cur_ok)) begin
            res_stat_nxt = spq_pkg::STAT_NONE;
          end else begin
            res_have_nxt = 1'b1;
            res_item_nxt = rd_entry;
            ctl.op       = spq_pkg::CELL_REMOVE;
            held_nxt     = held_r - CNT_W'(1);
            if (held_r == CNT_W'(1)) begin
              lowest_nxt = '0;
            end
          end
        end
        spq_pkg::REQ_CLEAR: begin
          held_nxt   = '0;
          lowest_nxt = '0;
        end
        default: res_stat_nxt = spq_pkg::STAT_OK;
      endcase
    end
  end

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CNT_W-1:0] POS = CNT_W'(g);
    logic            below_le;
    spq_pkg::entry_t below_q;
    spq_pkg::entry_t above_q;

    assign cell_valid[g] = POS < held_r;
    assign cell_rm[g]    = POS >= CNT_W'(rd_idx);

    if (g == 0) begin : g_first
      assign below_le = 1'b1;
      assign below_q  = cmd_entry_r;
    end else begin : g_inner
      assign below_le = cell_le[g-1];
      assign below_q  = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign above_q = cmd_entry_r;
    end else begin : g_lower
      assign above_q = cell_q[g+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid_i  (cell_valid[g]),
      .rm_sel   (cell_rm[g]),
      .below_le (below_le),
      .below_q  (below_q),
      .above_q  (above_q),
      .q        (cell_q[g]),
      .le       (cell_le[g])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      spacing_r   <= spq_pkg::SPACING_RST;
      held_r      <= '0;
      skip_r      <= '0;
      lowest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      skip_r   <= skip_nxt;
      lowest_r <= lowest_nxt;
      if (cfg_we) begin
        spacing_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_req.valid && in_ready) begin
      req_r             <= in_req.req_type;
      cmd_entry_r.btype <= in_req.build_type;
      cmd_entry_r.pri   <= p_eff;
      cmd_entry_r.blk   <= in_req.is_blocking;
      bottom_r          <= bottom_eff;
    end
    res_have_r <= res_have_nxt;
    res_item_r <= res_item_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_item_valid_r <= res_have_r;
      out_item_r       <= res_item_r;
      out_count_r      <= held_r;
      out_skip_r       <= can_skip;
      out_stat_r       <= res_stat_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.item_valid    = out_item_valid_r;
  assign out_rsp.item_type     = out_item_r.btype;
  assign out_rsp.item_priority = out_item_r.pri;
  assign out_rsp.item_blocking = out_item_r.blk;
  assign out_rsp.entry_count   = out_count_r;
  assign out_rsp.skip_allowed  = out_skip_r;
  assign out_rsp.status        = out_stat_r;

  // checks
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r == spq_pkg::S_EXEC))
    else $error("accepted transfer did not start execution");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_en && (res_stat_nxt == spq_pkg::STAT_FULL)) |=> (held_r == CNT_W'(DEPTH)))
    else $error("dropped insert changed the entry count");

  a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_valid_r) |-> (out_stat_r == spq_pkg::STAT_OK))
    else $error("returned entry with error status");

  a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_skip_r) |-> (out_count_r >= CNT_W'(2)))
    else $error("skip reported with fewer than two entries");

endmodule
